>>> rtl/satc_pkg.sv
package satc_pkg;

  // pending table depth default
  localparam int unsigned PendingDepth = 16;

  // request types
  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_FEEDBACK = 2'd1;
  localparam logic [1:0] REQ_SEND     = 2'd2;

  // feedback events
  localparam logic [1:0] EV_COLLISION = 2'd1;
  localparam logic [1:0] EV_CLEAR     = 2'd2;

  // transmit modes
  localparam logic [1:0] MODE_SENSE = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_COLL  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SENSE_TICKS = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_HIGH_POWER  = 2'd2;
  localparam logic [1:0] CFG_LOW_POWER   = 2'd3;

  // register reset values
  localparam logic [15:0] SenseTicksRst = 16'd50;
  localparam logic [15:0] AckTimeoutRst = 16'd100;
  localparam logic [15:0] HighPowerRst  = 16'hFFFF;
  localparam logic [15:0] LowPowerRst   = 16'd8192;

  // a zero window length falls back to this
  localparam logic [15:0] DefaultSense = 16'd50;
  localparam logic [7:0]  HeaderBytes  = 8'd4;
  localparam logic [7:0]  RetryMax     = 8'hFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  fb_event;
    logic        ack_valid;
    logic [15:0] ack_seq;
    logic [7:0]  payload_len;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        power_update;
    logic [15:0] power_level;
    logic        send_grant;
    logic        is_retransmit;
    logic [15:0] seq_out;
    logic [7:0]  retry_count;
    logic [7:0]  frame_len_byte;
    logic        pending_full;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  reg_idx;
    logic [15:0] wdata;
  } cfg_word_t;

  // one pending table entry
  typedef struct packed {
    logic [15:0] seq;
    logic [31:0] sent_time;
    logic [7:0]  retry;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_MATCH,
    CMD_DROP,
    CMD_ROTATE,
    CMD_APPEND
  } cell_cmd_e;

  // broadcast to every cell of the pending row
  typedef struct packed {
    cell_cmd_e   cmd;
    logic [15:0] ack_seq;
    entry_t      new_entry;
  } cell_ctl_t;

endpackage

>>> rtl/satc_stream_if.sv
interface satc_stream_if #(
  parameter type word_t = logic [0:0]
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/satc_cell.sv
module satc_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  satc_pkg::cell_ctl_t ctl_i,
  input  logic               left_valid_i,
  input  logic               right_valid_i,
  input  satc_pkg::entry_t   right_entry_i,
  input  logic               kill_i,
  output logic               valid_o,
  output satc_pkg::entry_t   entry_o,
  output logic               kill_o
);
  import satc_pkg::*;

  logic   valid_q, valid_d;
  logic   match_q, match_d;
  entry_t entry_q, entry_d;

  // an ack match here or in any cell to the left shifts this cell
  assign kill_o  = kill_i | match_q;
  assign valid_o = valid_q;
  assign entry_o = entry_q;

  always_comb begin
    valid_d = valid_q;
    match_d = match_q;
    entry_d = entry_q;
    unique case (ctl_i.cmd)
      CMD_HOLD: ;
      CMD_MATCH: match_d = valid_q && (entry_q.seq == ctl_i.ack_seq);
      CMD_DROP: begin
        if (kill_i || match_q) begin
          valid_d = right_valid_i;
          entry_d = right_entry_i;
        end
      end
      CMD_ROTATE: begin
        // the old tail position takes the resent entry
        if (valid_q && !right_valid_i) begin
          entry_d = ctl_i.new_entry;
        end else begin
          valid_d = right_valid_i;
          entry_d = right_entry_i;
        end
      end
      CMD_APPEND: begin
        if (!valid_q && left_valid_i) begin
          valid_d = 1'b1;
          entry_d = ctl_i.new_entry;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> rtl/sense_arq_transmit_control_unit.sv
// Transmit controller for a sensing MAC with automatic repeat of timed-out
// frames. One result word comes out for every input word. The block takes one
// word at a time: a tick, a send request or a feedback word without an ack
// passes from acceptance through the execute and done states to the output
// register, and the next word is accepted once the block is back in idle; a
// feedback word carrying an ack also passes through the drop state, since the
// pending row first registers its sequence compares and then closes the gap.
// A result still waiting for the receiver holds the next one back, so output
// stalls also hold off the next input word. The pending table is a row of
// PENDING_DEPTH identical cells, oldest entry in cell 0; each cell holds one
// entry and a valid bit and shifts from its right neighbor on removal, so
// resend-to-back and append are each a single row command and an ack removal
// a match then a drop, regardless of depth. A finished result waits in the
// output register while the next word is accepted; configuration words are
// taken at any time and must be written only while the block is idle.
module sense_arq_transmit_control_unit #(
  parameter int unsigned PENDING_DEPTH = satc_pkg::PendingDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  satc_stream_if.sink   in_i,
  satc_stream_if.source out_o,
  satc_stream_if.sink   cfg_i
);
  import satc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DROP,
    ST_DONE
  } state_e;

  state_e      state_q, state_d;
  in_word_t    in_q;
  out_word_t   res_q, res_d;
  out_word_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;

  // controller state
  logic [1:0]  mode_q, mode_d;
  logic [15:0] win_q, win_d;
  logic        coll_q, coll_d;
  logic [15:0] next_seq_q, next_seq_d;
  logic [31:0] now_q, now_d;

  // configuration registers
  logic [15:0] sense_ticks_q;
  logic [15:0] ack_timeout_q;
  logic [15:0] high_power_q;
  logic [15:0] low_power_q;

  // pending row
  cell_ctl_t   cell_ctl;
  logic [PENDING_DEPTH-1:0] cell_valid;
  logic [PENDING_DEPTH-1:0] cell_kill;
  entry_t      cell_entry [PENDING_DEPTH];

  logic        in_fire;
  logic [15:0] win_len;
  logic [15:0] win_next;
  logic [15:0] upper_pw;
  logic [15:0] lower_pw;
  logic [31:0] head_age;
  logic        head_timed_out;
  logic        table_full;

  // ---------------------------------------------------------------------
  // chain of pending cells, cell 0 holds the oldest entry
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < PENDING_DEPTH; g++) begin : g_cell
    logic   left_valid;
    logic   right_valid;
    logic   kill_in;
    entry_t right_entry;

    if (g == 0) begin : g_head
      assign left_valid = 1'b1;
      assign kill_in    = 1'b0;
    end else begin : g_body
      assign left_valid = cell_valid[g-1];
      assign kill_in    = cell_kill[g-1];
    end

    if (g == PENDING_DEPTH - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_entry = '0;
    end else begin : g_mid
      assign right_valid = cell_valid[g+1];
      assign right_entry = cell_entry[g+1];
    end

    satc_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (cell_ctl),
      .left_valid_i  (left_valid),
      .right_valid_i (right_valid),
      .right_entry_i (right_entry),
      .kill_i        (kill_in),
      .valid_o       (cell_valid[g]),
      .entry_o       (cell_entry[g]),
      .kill_o        (cell_kill[g])
    );
  end

  // ---------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // ---------------------------------------------------------------------
  // shared datapath pieces
  // ---------------------------------------------------------------------
  assign win_len  = (sense_ticks_q == '0) ? DefaultSense : sense_ticks_q;
  assign win_next = win_q + 16'd1;
  assign upper_pw = (high_power_q > low_power_q) ? high_power_q : low_power_q;
  assign lower_pw = (high_power_q > low_power_q) ? low_power_q : high_power_q;

  // wrapped age of the oldest entry against the ack timeout
  assign head_age       = now_q - cell_entry[0].sent_time;
  assign head_timed_out = cell_valid[0] && (head_age > {16'd0, ack_timeout_q});
  assign table_full     = cell_valid[PENDING_DEPTH-1];

  // ---------------------------------------------------------------------
  // next state and result
  // ---------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mode_d      = mode_q;
    win_d       = win_q;
    coll_d      = coll_q;
    next_seq_d  = next_seq_q;
    now_d       = now_q;

    cell_ctl.cmd       = CMD_HOLD;
    cell_ctl.ack_seq   = in_q.ack_seq;
    cell_ctl.new_entry = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_d   = '0;
        state_d = ST_DONE;
        case (in_q.req_type)
          REQ_TICK: begin
            now_d = now_q + 32'd1;
            if (mode_q == MODE_SENSE) begin
              win_d = win_next;
              if (win_next >= win_len) begin
                win_d = '0;
                if (coll_q) begin
                  // collision seen in this window: sense once more
                  coll_d = 1'b0;
                end else begin
                  mode_d             = MODE_CLEAR;
                  res_d.power_update = 1'b1;
                  res_d.power_level  = upper_pw;
                end
              end
            end
          end

          REQ_FEEDBACK: begin
            if (mode_q == MODE_SENSE) begin
              if (in_q.fb_event == EV_COLLISION) begin
                coll_d = 1'b1;
              end
            end else if (mode_q == MODE_CLEAR) begin
              if (in_q.fb_event == EV_COLLISION) begin
                mode_d             = MODE_COLL;
                res_d.power_update = 1'b1;
                res_d.power_level  = lower_pw;
              end
            end else begin
              if (in_q.fb_event == EV_CLEAR) begin
                mode_d = MODE_SENSE;
                win_d  = '0;
                coll_d = 1'b0;
              end
            end
            // ack removal: compare this cycle, close the gap next cycle
            if (in_q.ack_valid) begin
              cell_ctl.cmd = CMD_MATCH;
              state_d      = ST_DROP;
            end
          end

          REQ_SEND: begin
            if (mode_q != MODE_SENSE) begin
              res_d.send_grant     = 1'b1;
              res_d.frame_len_byte = in_q.payload_len + HeaderBytes;
              if (head_timed_out) begin
                // resend the oldest entry and move it to the back
                res_d.is_retransmit = 1'b1;
                res_d.seq_out       = cell_entry[0].seq;
                res_d.retry_count   = (cell_entry[0].retry == RetryMax) ?
                                      RetryMax : cell_entry[0].retry + 8'd1;
                cell_ctl.cmd                 = CMD_ROTATE;
                cell_ctl.new_entry.seq       = cell_entry[0].seq;
                cell_ctl.new_entry.sent_time = now_q;
                cell_ctl.new_entry.retry     = res_d.retry_count;
              end else begin
                res_d.seq_out = next_seq_q;
                next_seq_d    = next_seq_q + 16'd1;
                if (table_full) begin
                  res_d.pending_full = 1'b1;
                end else begin
                  cell_ctl.cmd                 = CMD_APPEND;
                  cell_ctl.new_entry.seq       = next_seq_q;
                  cell_ctl.new_entry.sent_time = now_q;
                  cell_ctl.new_entry.retry     = '0;
                end
              end
            end
          end

          default: ;
        endcase
        res_d.mode = mode_d;
      end

      ST_DROP: begin
        cell_ctl.cmd = CMD_DROP;
        state_d      = ST_DONE;
      end

      ST_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      mode_q        <= MODE_SENSE;
      win_q         <= '0;
      coll_q        <= 1'b0;
      next_seq_q    <= '0;
      now_q         <= '0;
      sense_ticks_q <= SenseTicksRst;
      ack_timeout_q <= AckTimeoutRst;
      high_power_q  <= HighPowerRst;
      low_power_q   <= LowPowerRst;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      mode_q      <= mode_d;
      win_q       <= win_d;
      coll_q      <= coll_d;
      next_seq_q  <= next_seq_d;
      now_q       <= now_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.data.reg_idx)
          CFG_SENSE_TICKS: sense_ticks_q <= cfg_i.data.wdata;
          CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_i.data.wdata;
          CFG_HIGH_POWER:  high_power_q  <= cfg_i.data.wdata;
          CFG_LOW_POWER:   low_power_q   <= cfg_i.data.wdata;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_i.data;
    end
    res_q <= res_d;
    out_q <= out_d;
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------

  // valid cells always form an unbroken run starting at cell 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("pending row has a hole");

  // an accepted word is executed in the very next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_EXEC))
    else $error("accepted word not executed");

  // no grant is ever reported while sensing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.send_grant && (out_q.mode == MODE_SENSE)))
    else $error("grant reported in sensing mode");

  // a power announcement always comes with a mode change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) && res_d.power_update |-> (mode_d != mode_q))
    else $error("power update without mode change");

  // never append into a full row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_ctl.cmd == CMD_APPEND) |-> !table_full)
    else $error("append into full pending row");

endmodule

>>> sim/satc_result_checker.sv
`timescale 1ns / 100ps
module satc_result_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  satc_pkg::in_word_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  satc_pkg::out_word_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  satc_pkg::cfg_word_t cfg_data_i,
  output int unsigned         errors_o,
  output int unsigned         waiting_o
);
  import satc_pkg::*;

  // register copies
  logic [15:0] win_len;
  logic [15:0] ack_tmo;
  logic [15:0] pwr_hi;
  logic [15:0] pwr_lo;

  // controller state
  logic [1:0]  mode_q;
  logic [15:0] win_cnt;
  logic        coll_seen;
  logic [15:0] seq_next;
  logic [31:0] tick_now;
  entry_t      pend_q[$];

  out_word_t   due_words[$];
  out_word_t   want;
  out_word_t   pred;
  int unsigned fail_cnt;
  int unsigned waiting_cnt;

  assign errors_o  = fail_cnt;
  assign waiting_o = waiting_cnt;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, exp_val));
  endtask

  // advances the controller by one input word and returns its result word
  function automatic out_word_t step_controller(in_word_t w);
    out_word_t   r;
    logic [15:0] win;
    logic [31:0] age;
    entry_t      e;
    int          i;
    logic        hit;
    r = '0;
    case (w.req_type)
      REQ_TICK: begin
        tick_now = tick_now + 32'd1;
        if (mode_q == MODE_SENSE) begin
          win = (win_len != 16'd0) ? win_len : DefaultSense;
          win_cnt = win_cnt + 16'd1;
          if (win_cnt >= win) begin
            win_cnt = '0;
            if (coll_seen) begin
              coll_seen = 1'b0;
            end else begin
              mode_q = MODE_CLEAR;
              r.power_update = 1'b1;
              r.power_level = (pwr_hi > pwr_lo) ? pwr_hi : pwr_lo;
            end
          end
        end
      end
      REQ_FEEDBACK: begin
        case (mode_q)
          MODE_SENSE: begin
            if (w.fb_event == EV_COLLISION) coll_seen = 1'b1;
          end
          MODE_CLEAR: begin
            if (w.fb_event == EV_COLLISION) begin
              mode_q = MODE_COLL;
              r.power_update = 1'b1;
              r.power_level = (pwr_hi > pwr_lo) ? pwr_lo : pwr_hi;
            end
          end
          default: begin
            if (w.fb_event == EV_CLEAR) begin
              mode_q = MODE_SENSE;
              win_cnt = '0;
              coll_seen = 1'b0;
            end
          end
        endcase
        // oldest matching entry goes
        if (w.ack_valid) begin
          hit = 1'b0;
          i = 0;
          while (!hit && i < pend_q.size()) begin
            if (pend_q[i].seq == w.ack_seq) begin
              pend_q.delete(i);
              hit = 1'b1;
            end
            i++;
          end
        end
      end
      REQ_SEND: begin
        if (mode_q != MODE_SENSE) begin
          r.send_grant = 1'b1;
          r.frame_len_byte = w.payload_len + HeaderBytes;
          age = (pend_q.size() > 0) ? tick_now - pend_q[0].sent_time : '0;
          if (pend_q.size() > 0 && age > {16'd0, ack_tmo}) begin
            e = pend_q[0];
            pend_q.delete(0);
            if (e.retry != RetryMax) e.retry = e.retry + 8'd1;
            e.sent_time = tick_now;
            pend_q.insert(pend_q.size(), e);
            r.is_retransmit = 1'b1;
            r.seq_out = e.seq;
            r.retry_count = e.retry;
          end else begin
            r.seq_out = seq_next;
            if (pend_q.size() < PendingDepth) begin
              e.seq = seq_next;
              e.sent_time = tick_now;
              e.retry = 8'd0;
              pend_q.insert(pend_q.size(), e);
            end else begin
              r.pending_full = 1'b1;
            end
            seq_next = seq_next + 16'd1;
          end
        end
      end
      default: ;
    endcase
    r.mode = mode_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len = SenseTicksRst;
      ack_tmo = AckTimeoutRst;
      pwr_hi = HighPowerRst;
      pwr_lo = LowPowerRst;
      mode_q = MODE_SENSE;
      win_cnt = '0;
      coll_seen = 1'b0;
      seq_next = '0;
      tick_now = '0;
      pend_q.delete();
      due_words.delete();
      fail_cnt = 0;
      waiting_cnt = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_words.size() == 0) begin
          report_mismatch("result word with nothing outstanding");
        end else begin
          want = due_words[0];
          due_words.delete(0);
          check_field("mode", 32'(out_data_i.mode), 32'(want.mode));
          check_field("power_update", 32'(out_data_i.power_update),
                      32'(want.power_update));
          check_field("power_level", 32'(out_data_i.power_level),
                      32'(want.power_level));
          check_field("send_grant", 32'(out_data_i.send_grant), 32'(want.send_grant));
          check_field("is_retransmit", 32'(out_data_i.is_retransmit),
                      32'(want.is_retransmit));
          check_field("seq_out", 32'(out_data_i.seq_out), 32'(want.seq_out));
          check_field("retry_count", 32'(out_data_i.retry_count),
                      32'(want.retry_count));
          check_field("frame_len_byte", 32'(out_data_i.frame_len_byte),
                      32'(want.frame_len_byte));
          check_field("pending_full", 32'(out_data_i.pending_full),
                      32'(want.pending_full));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_data_i.reg_idx)
          CFG_SENSE_TICKS: win_len = cfg_data_i.wdata;
          CFG_ACK_TIMEOUT: ack_tmo = cfg_data_i.wdata;
          CFG_HIGH_POWER:  pwr_hi = cfg_data_i.wdata;
          default:         pwr_lo = cfg_data_i.wdata;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        pred = step_controller(in_data_i);
        due_words.insert(due_words.size(), pred);
      end
      waiting_cnt = due_words.size();
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
module tb;
  import satc_pkg::*;

  // request and event codes the package leaves unnamed
  localparam logic [1:0] REQ_RESERVED = 2'd3;
  localparam logic [1:0] EV_OTHER     = 2'd0;
  localparam logic [1:0] EV_RESERVED  = 2'd3;

  // worst correct stretch without a handshake: a sender gap, a receiver stall
  // and the block's own latency; taken many times
  localparam int unsigned StallLimit = 2000;
  // ack words pass through execute, drop and done before the output register, so a short pause covers them
  localparam int unsigned LatencyPause = 8;
  // ticks tried before giving up on leaving sensing
  localparam int unsigned SenseTries = 100;

  logic clk;
  logic rst_n;

  satc_stream_if #(.word_t(in_word_t))  in_if ();
  satc_stream_if #(.word_t(out_word_t)) out_if ();
  satc_stream_if #(.word_t(cfg_word_t)) cfg_if ();

  sense_arq_transmit_control_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  int unsigned mismatches;
  int unsigned results_due;

  // watches all three channels, predicts each result word and compares
  satc_result_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_if.valid),
    .in_ready_i (in_if.ready),
    .in_data_i  (in_if.data),
    .out_valid_i(out_if.valid),
    .out_ready_i(out_if.ready),
    .out_data_i (out_if.data),
    .cfg_valid_i(cfg_if.valid),
    .cfg_ready_i(cfg_if.ready),
    .cfg_data_i (cfg_if.data),
    .errors_o   (mismatches),
    .waiting_o  (results_due)
  );

  // random idling on both sides while set
  logic idle_en;

  // last mode and sequence seen on the output, used only to steer stimulus
  logic [1:0]  seen_mode = MODE_SENSE;
  logic [15:0] seen_seq  = '0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (out_if.valid && out_if.ready) begin
      seen_mode <= out_if.data.mode;
      if (out_if.data.send_grant) seen_seq <= out_if.data.seq_out;
    end
  end

  // receiver: ready drops in bursts whose length is drawn at random
  initial begin
    int unsigned hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        hold--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 9);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // sender gap: valid drops low, its length given by n
  task automatic pause_sender(input int unsigned n);
    @(negedge clk);
    in_if.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // valid stays high after acceptance so back-to-back words need no re-raise
  task automatic send_word(input in_word_t w);
    if (idle_en && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 10));
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic send_fields(input logic [1:0] req, input logic [1:0] ev,
                             input logic ackv, input logic [15:0] ack,
                             input logic [7:0] plen);
    send_word({req, ev, ackv, ack, plen});
  endtask

  // sender holds off until every outstanding result word has come back
  task automatic settle_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (LatencyPause) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= {idx, val};
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // registers only change with the block idle
  task automatic set_config(input logic [15:0] sense, input logic [15:0] tmo,
                            input logic [15:0] hi, input logic [15:0] lo);
    settle_results();
    write_reg(CFG_SENSE_TICKS, sense);
    write_reg(CFG_ACK_TIMEOUT, tmo);
    write_reg(CFG_HIGH_POWER, hi);
    write_reg(CFG_LOW_POWER, lo);
  endtask

  // ticks until the output reports clear or collision; needs a short window
  task automatic leave_sensing();
    int unsigned tries;
    tries = 0;
    settle_results();
    while (seen_mode == MODE_SENSE && tries < SenseTries) begin
      send_fields(REQ_TICK, EV_OTHER, 1'b0, '0, '0);
      settle_results();
      tries++;
    end
  endtask

  // mostly ticks and sends, acks aimed at recently granted sequences
  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      w.req_type = REQ_TICK;
    else if (pick < 60) w.req_type = REQ_FEEDBACK;
    else if (pick < 97) w.req_type = REQ_SEND;
    else                w.req_type = REQ_RESERVED;
    w.fb_event  = 2'($urandom_range(0, 3));
    w.ack_valid = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 6) w.ack_seq = seen_seq - 16'($urandom_range(0, 20));
    else w.ack_seq = 16'($urandom);
    w.payload_len = 8'($urandom);
    return w;
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned done;
    in_word_t    w;
    done = 0;
    while (done < count) begin
      w = random_word();
      send_word(w);
      if (w.req_type != REQ_RESERVED) done++;
      if (idle_en && $urandom_range(0, 199) == 0) settle_results();
    end
  endtask

  initial begin
    idle_en = 1'b1;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: a two tick window keeps the mode walk short
    write_reg(CFG_SENSE_TICKS, 16'd2);
    send_fields(REQ_SEND, EV_OTHER, 1'b0, '0, 8'd10);           // sending while sensing
    send_fields(REQ_RESERVED, EV_COLLISION, 1'b1, '0, 8'hFF);   // unused request type
    send_fields(REQ_FEEDBACK, EV_COLLISION, 1'b1, 16'hFFFF, '0); // collision, ack on empty table
    send_fields(REQ_TICK, EV_OTHER, 1'b0, '0, '0);
    send_fields(REQ_TICK, EV_OTHER, 1'b0, '0, '0);              // window restarts
    send_fields(REQ_TICK, EV_OTHER, 1'b0, '0, '0);
    send_fields(REQ_TICK, EV_OTHER, 1'b0, '0, '0);              // clean window: clear, high power
    send_fields(REQ_SEND, EV_OTHER, 1'b0, '0, 8'd0);
    send_fields(REQ_SEND, EV_OTHER, 1'b0, '0, 8'hFF);           // length byte wraps
    send_fields(REQ_SEND, EV_CLEAR, 1'b1, 16'hFFFF, 8'hA5);
    send_fields(REQ_FEEDBACK, EV_RESERVED, 1'b1, 16'd1, '0);    // spare event, middle entry acked
    send_fields(REQ_FEEDBACK, EV_OTHER, 1'b1, 16'h1234, '0);    // ack of a sequence not pending
    send_fields(REQ_FEEDBACK, EV_CLEAR, 1'b0, '0, '0);          // clear while clear: no change
    send_fields(REQ_FEEDBACK, EV_COLLISION, 1'b1, 16'd0, '0);   // collision, low power
    send_fields(REQ_SEND, EV_OTHER, 1'b0, '0, 8'h5A);
    send_fields(REQ_FEEDBACK, EV_COLLISION, 1'b0, '0, '0);      // collision while collision
    send_fields(REQ_TICK, EV_OTHER, 1'b0, '0, '0);
    send_fields(REQ_FEEDBACK, EV_CLEAR, 1'b0, '0, '0);          // back to sensing
    send_fields(REQ_SEND, EV_OTHER, 1'b0, '0, 8'h33);
    send_fields(REQ_TICK, EV_OTHER, 1'b0, '0, '0);
    send_fields(REQ_TICK, EV_OTHER, 1'b0, '0, '0);
    send_fields(REQ_FEEDBACK, EV_OTHER, 1'b1, 16'd2, '0);       // acks empty the table
    send_fields(REQ_FEEDBACK, EV_OTHER, 1'b1, 16'd3, '0);

    // retry saturation: one pending entry, zero timeout, a tick before each resend
    set_config(16'd1, 16'd0, 16'($urandom), 16'($urandom));
    leave_sensing();
    send_fields(REQ_SEND, EV_OTHER, 1'b0, '0, 8'($urandom));
    repeat (258) begin
      send_fields(REQ_TICK, EV_OTHER, 1'b0, '0, '0);
      send_fields(REQ_SEND, EV_OTHER, 1'b0, '0, 8'($urandom));
    end
    settle_results();
    send_fields(REQ_FEEDBACK, EV_OTHER, 1'b1, seen_seq, '0);

    // long timeout, more new sequences than table entries
    set_config(16'd1, 16'hFFFF, 16'hFFFF, 16'd8192);
    leave_sensing();
    repeat (18) send_fields(REQ_SEND, EV_OTHER, 1'b0, '0, 8'($urandom));

    // random phases over several register settings
    set_config(16'd1, 16'd3, 16'h8000, 16'h7FFF);
    run_random(140);
    set_config(16'd3, 16'd0, 16'h0000, 16'hFFFF);   // levels swapped
    run_random(140);
    set_config(16'd0, 16'd10, 16'hFFFF, 16'h0000);  // zero window acts as the default
    run_random(120);
    set_config(16'hFFFF, 16'hFFFF, 16'h1234, 16'h1234);
    run_random(60);
    set_config(16'd1, 16'd1, 16'($urandom), 16'($urandom));
    run_random(120);

    // last part without idling
    idle_en = 1'b0;
    set_config(16'd2, 16'd5, 16'($urandom), 16'($urandom));
    run_random(150);

    settle_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/satc_pkg.sv
rtl/satc_stream_if.sv
rtl/satc_cell.sv
rtl/sense_arq_transmit_control_unit.sv
sim/satc_result_checker.sv
sim/tb.sv
